// ===== sv/b32se_pkg.sv =====
package b32se_pkg;

	localparam int GRP_W         = 5;
	localparam int CAT_W         = 12;
	localparam int HELD_W        = 3;
	localparam int KEEP_W        = 4;
	localparam int CNT_W         = 8;
	localparam int SYM_W         = 7;
	localparam int NUM_W         = 2;
	localparam int MAX_GRP       = 3;
	localparam int JOBQ_DEPTH    = 4;
	localparam int OUTQ_DEPTH    = 2;
	localparam int MAX_CHARS_DEF = 63;

	typedef logic [GRP_W-1:0] group_t;

	// one byte's worth of work for the back end
	typedef struct packed {
		group_t [MAX_GRP-1:0] grp;
		logic   [NUM_W-1:0]   num;   // symbols to send, 1..3
		logic                 last;  // final symbol closes the record
	} job_t;

	// 5-bit group to punctuation character
	function automatic logic [SYM_W-1:0] sym_lut(input group_t g);
		logic [SYM_W-1:0] c;
		unique case (g)
			5'd0:  c = 7'h20;
			5'd1:  c = 7'h21;
			5'd2:  c = 7'h22;
			5'd3:  c = 7'h23;
			5'd4:  c = 7'h24;
			5'd5:  c = 7'h25;
			5'd6:  c = 7'h26;
			5'd7:  c = 7'h27;
			5'd8:  c = 7'h28;
			5'd9:  c = 7'h29;
			5'd10: c = 7'h2A;
			5'd11: c = 7'h2B;
			5'd12: c = 7'h60;
			5'd13: c = 7'h2D;
			5'd14: c = 7'h2E;
			5'd15: c = 7'h2F;
			5'd16: c = 7'h3A;
			5'd17: c = 7'h3B;
			5'd18: c = 7'h3C;
			5'd19: c = 7'h3D;
			5'd20: c = 7'h3E;
			5'd21: c = 7'h3F;
			5'd22: c = 7'h5B;
			5'd23: c = 7'h5C;
			5'd24: c = 7'h5D;
			5'd25: c = 7'h5E;
			5'd26: c = 7'h5F;
			5'd27: c = 7'h7B;
			5'd28: c = 7'h7C;
			5'd29: c = 7'h7D;
			5'd30: c = 7'h7E;
			default: c = 7'h40;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/b32se_front.sv =====
module b32se_front import b32se_pkg::*; #(
	parameter int MAX_CHARS = MAX_CHARS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [7:0]       data_byte,
	input  logic             end_of_record,
	output logic             full,
	input  logic             jq_full,
	output logic             jq_push,
	output job_t             jq_data
);

	localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_CHARS);

	logic [KEEP_W-1:0] buf_q;
	logic [HELD_W-1:0] held_q;
	logic [CNT_W-1:0]  sent_q;
	logic              done_q;

	logic              acc;
	logic [CAT_W-1:0]  cat;
	logic [KEEP_W-1:0] tot;
	logic              two;
	logic [HELD_W-1:0] rem;
	group_t            g0, g1, pad;
	logic [NUM_W-1:0]  nc, num;
	logic [CNT_W-1:0]  left;
	logic              hit;
	logic [KEEP_W-1:0] keep_mask;

	assign full = jq_full;
	assign acc  = push & ~jq_full;

	always_comb begin
		cat       = {buf_q, data_byte};
		tot       = KEEP_W'(held_q) + KEEP_W'(8);
		two       = (tot >= KEEP_W'(10));
		g0        = GRP_W'(cat >> (tot - KEEP_W'(5)));
		g1        = GRP_W'(cat >> (tot - KEEP_W'(10)));
		rem       = two ? HELD_W'(tot - KEEP_W'(10)) : HELD_W'(tot - KEEP_W'(5));
		// leftover bits, zero padded at the low end
		pad       = GRP_W'(cat[GRP_W-1:0] << (HELD_W'(5) - rem));
		nc        = (two ? NUM_W'(2) : NUM_W'(1))
		          + NUM_W'(end_of_record && (rem != '0));
		left      = MAX_C - sent_q;
		hit       = (left <= CNT_W'(nc));
		num       = hit ? left[NUM_W-1:0] : nc;
		keep_mask = KEEP_W'((5'd1 << rem) - 5'd1);

		jq_data.grp[0] = g0;
		jq_data.grp[1] = two ? g1 : pad;
		jq_data.grp[2] = pad;
		jq_data.num    = num;
		jq_data.last   = end_of_record | hit;
		jq_push        = acc & ~done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			held_q <= '0;
			sent_q <= '0;
			done_q <= 1'b0;
		end else if (acc) begin
			if (end_of_record) begin
				buf_q  <= '0;
				held_q <= '0;
				sent_q <= '0;
				done_q <= 1'b0;
			end else if (!done_q) begin
				sent_q <= sent_q + CNT_W'(num);
				if (hit) begin
					done_q <= 1'b1;
					buf_q  <= '0;
					held_q <= '0;
				end else begin
					buf_q  <= cat[KEEP_W-1:0] & keep_mask;
					held_q <= rem;
				end
			end
		end
	end

endmodule

// ===== sv/b32se_jobq.sv =====
module b32se_jobq import b32se_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_data,
	output logic q_full,
	input  logic rd,
	output job_t rd_data,
	output logic q_empty
);

	localparam int AW = $clog2(JOBQ_DEPTH);
	localparam int CW = $clog2(JOBQ_DEPTH + 1);

	job_t          mem_q [JOBQ_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign q_full  = (cnt_q == CW'(JOBQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr & ~q_full;
	assign do_rd   = rd & ~q_empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= rp_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== sv/b32se_back.sv =====
module b32se_back import b32se_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  job_t             job,
	input  logic             job_empty,
	output logic             job_pop,
	input  logic             pop,
	output logic             empty,
	output logic [SYM_W-1:0] symbol,
	output logic             last_symbol
);

	localparam int AW = $clog2(OUTQ_DEPTH);
	localparam int CW = $clog2(OUTQ_DEPTH + 1);

	logic [NUM_W-1:0] idx_q;
	logic [SYM_W-1:0] sym_q [OUTQ_DEPTH];
	logic             lst_q [OUTQ_DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;

	logic             oq_full, emit, at_end, do_rd;
	logic [SYM_W-1:0] new_sym;
	logic             new_lst;

	assign oq_full     = (cnt_q == CW'(OUTQ_DEPTH));
	assign empty       = (cnt_q == '0);
	assign do_rd       = pop & ~empty;
	assign emit        = ~job_empty & ~oq_full;
	assign at_end      = (idx_q == job.num - NUM_W'(1));
	assign job_pop     = emit & at_end;
	assign new_sym     = sym_lut(job.grp[idx_q]);
	assign new_lst     = job.last & at_end;
	assign symbol      = sym_q[rp_q];
	assign last_symbol = lst_q[rp_q];

	always_ff @(posedge clk) begin
		if (emit) begin
			sym_q[wp_q] <= new_sym;
			lst_q[wp_q] <= new_lst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (emit) begin
				idx_q <= at_end ? '0 : idx_q + NUM_W'(1);
				wp_q  <= wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= rp_q + AW'(1);
			end
			if (emit && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !emit) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== sv/base32_symbol_encoder_unit.sv =====
// Byte-to-punctuation base32 encoder.
// Input side is a queue: drive data_byte / end_of_record with push; a request
// is taken on a clock edge with push high and full low. Mark the final byte
// of each record with end_of_record.
// Output side is a queue: while empty is low, symbol / last_symbol hold the
// oldest result; pulse pop to take it. last_symbol flags the record's final
// symbol (limit of MAX_CHARS reached, or end of record, zero-padded if bits remain).
// Bytes after the limit produce nothing until end_of_record.
// A taken byte's job is written into the job queue; its first symbol is then
// registered into the output queue, from which it can be popped.
// Throughput: the back end sends one symbol per cycle while a job waits and
// the output queue has room; a byte makes one to three symbols, 1.6 on average.
// A four-entry job queue sits between the classifying front end and the
// symbol back end, and a two-entry output queue follows, so the input keeps
// flowing while results wait. When the receiver stops popping, the queues
// fill and full rises; nothing is dropped.
// Reset (arst_n low) empties both queues and starts a fresh record.
module base32_symbol_encoder_unit import b32se_pkg::*; #(
	parameter int MAX_CHARS = MAX_CHARS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       data_byte,
	input  logic             end_of_record,
	output logic             empty,
	input  logic             pop,
	output logic [SYM_W-1:0] symbol,
	output logic             last_symbol
);

	job_t wr_job, rd_job;
	logic jq_push, jq_full, jq_pop, jq_empty;

	// front end: bit regrouping, symbol limit, tail padding
	b32se_front #(.MAX_CHARS(MAX_CHARS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.data_byte     (data_byte),
		.end_of_record (end_of_record),
		.full          (full),
		.jq_full       (jq_full),
		.jq_push       (jq_push),
		.jq_data       (wr_job)
	);

	// decouples the two halves
	b32se_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (jq_push),
		.wr_data (wr_job),
		.q_full  (jq_full),
		.rd      (jq_pop),
		.rd_data (rd_job),
		.q_empty (jq_empty)
	);

	// back end: one symbol per cycle, while a job waits and the output queue has room, through the alphabet table
	b32se_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (rd_job),
		.job_empty   (jq_empty),
		.job_pop     (jq_pop),
		.pop         (pop),
		.empty       (empty),
		.symbol      (symbol),
		.last_symbol (last_symbol)
	);

endmodule
